/* rtl/ghe_pkg.sv */
// geohash encoder package: widths, range limits, alphabet and the token type
// passed along the chain of character cells
// no dependencies
package ghe_pkg;

	localparam int MAX_CHARS = 12;
	localparam int CNT_W     = 4;
	localparam int LNG_W     = 32;
	localparam int LAT_W     = 31;

	localparam logic [CNT_W-1:0] CNT_DEFAULT = 4'd6;

	// half range of each axis in input units (2^-23 degree)
	localparam logic [LNG_W-1:0] LNG_HALF = 32'd1509949440;
	localparam logic [LAT_W-1:0] LAT_HALF = 31'd754974720;

	localparam logic signed [31:0] LNG_LIM_S = 32'sd1509949440;
	localparam logic signed [31:0] LAT_LIM_S = 32'sd754974720;

	localparam logic [255:0] ALPHA_STR = "0123456789bcdefghjkmnpqrstuvwxyz";

	typedef struct packed {
		logic             vld;
		logic             cv;
		logic             last;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] pos;
		logic [7:0]       ch;
		logic [LNG_W-1:0] lng_r;
		logic [LAT_W-1:0] lat_r;
	} tok_t;

	function automatic logic [7:0] geo_char(logic [4:0] idx);
		return ALPHA_STR[{5'd31 - idx, 3'b000} +: 8];
	endfunction

endpackage

/* rtl/geohash_encoder_core.sv */
// geohash encoder top level: input stage, chain of character cells, output register
// depends on ghe_pkg and ghe_cell
//
// One latitude/longitude beat yields char_count geohash characters (1..12,
// any other setting gives 6), one result beat per character in order, the
// final one flagged by hash_last. A coordinate out of range yields a single
// beat with coord_valid low. Characters leave at one per cycle while
// out_ready is high; an item passes from the input stage along the chain
// of twelve cells, one cell per character (only the first for a coordinate
// out of range), each cell doing five bisection steps. The next item is
// taken while the last character still waits in the output register.
module geohash_encoder_core import ghe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CNT_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         hash_char,
	output logic [CNT_W-1:0]   char_position,
	output logic               coord_valid,
	output logic               hash_last
);

	logic [CNT_W-1:0] char_count_q;
	logic             fr_vld_q;
	tok_t             fr_q;
	tok_t             tok [MAX_CHARS+1];
	logic [MAX_CHARS-1:0] cell_vld;
	logic             in_acc;
	logic             move;
	logic             any_vld;
	tok_t             sel;
	logic             out_vld_q;
	logic [7:0]       ch_q;
	logic [CNT_W-1:0] pos_q;
	logic             cv_q;
	logic             last_q;
	logic signed [32:0] lat_sum;
	logic signed [32:0] lng_sum;
	logic             in_range;

	assign in_ready = !fr_vld_q && !any_vld;
	assign in_acc   = in_valid && in_ready;
	assign move     = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= CNT_DEFAULT;
		end else if (cfg_wr_en) begin
			char_count_q <= cfg_wr_data;
		end
	end

	// input stage
	assign lat_sum  = {latitude[31], latitude} + 33'sd754974720;
	assign lng_sum  = {longitude[31], longitude} + 33'sd1509949440;
	assign in_range = (latitude <= LAT_LIM_S) && (latitude >= -LAT_LIM_S) &&
		(longitude <= LNG_LIM_S) && (longitude >= -LNG_LIM_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_q <= 1'b0;
		end else begin
			fr_vld_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fr_q.vld   <= 1'b1;
			fr_q.cv    <= in_range;
			fr_q.last  <= 1'b0;
			fr_q.cnt   <= (char_count_q != '0 && char_count_q <= CNT_W'(MAX_CHARS)) ?
				char_count_q : CNT_DEFAULT;
			fr_q.pos   <= '0;
			fr_q.ch    <= '0;
			fr_q.lng_r <= lng_sum[LNG_W-1:0];
			fr_q.lat_r <= lat_sum[LAT_W-1:0];
		end
	end

	always_comb begin
		tok[0]     = fr_q;
		tok[0].vld = fr_vld_q;
	end

	// chain of character cells
	for (genvar c = 0; c < MAX_CHARS; c++) begin : g_cell
		logic ld;
		if (c == 0) begin : g_first
			assign ld = fr_vld_q;
		end else begin : g_rest
			assign ld = move && tok[c].vld && !tok[c].last;
		end
		ghe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.pos    (CNT_W'(c)),
			.load   (ld),
			.clear  (move && tok[c+1].vld),
			.tok_i  (tok[c]),
			.tok_o  (tok[c+1])
		);
		assign cell_vld[c] = tok[c+1].vld;
	end

	assign any_vld = |cell_vld;

	always_comb begin
		sel = '0;
		for (int k = 0; k < MAX_CHARS; k++) begin
			if (tok[k+1].vld) begin
				sel = sel | tok[k+1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move) begin
			out_vld_q <= any_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (move && any_vld) begin
			ch_q   <= sel.ch;
			pos_q  <= sel.pos;
			cv_q   <= sel.cv;
			last_q <= sel.last;
		end
	end

	assign out_valid     = out_vld_q;
	assign hash_char     = ch_q;
	assign char_position = pos_q;
	assign coord_valid   = cv_q;
	assign hash_last     = last_q;

	// one item in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({fr_vld_q, cell_vld}))
		else $error("more than one token in the cell chain");

	a_bad_coord: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !coord_valid |-> hash_last && char_position == '0 && hash_char == '0)
		else $error("out of range beat not a single empty result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && fr_vld_q)
		else $error("accepted beat not held in input stage");

endmodule

/* rtl/ghe_cell.sv */
// geohash encoder cell: five bisection steps giving one character, registered
// depends on ghe_pkg
module ghe_cell import ghe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] pos,
	input  logic             load,
	input  logic             clear,
	input  tok_t             tok_i,
	output tok_t             tok_o
);

	logic vld_q;
	tok_t pay_q;
	tok_t nxt;

	// residual r = (coord - low) * 2^k; bit is r > half, then r doubles
	always_comb begin
		logic [LNG_W-1:0] lr;
		logic [LAT_W-1:0] ar;
		logic [4:0]       sym;
		logic             b;
		lr  = tok_i.lng_r;
		ar  = tok_i.lat_r;
		sym = '0;
		for (int j = 0; j < 5; j++) begin
			if (pos[0] ^ j[0]) begin
				b  = ar > LAT_HALF;
				ar = b ? ((ar - LAT_HALF) << 1) : (ar << 1);
			end else begin
				b  = lr > LNG_HALF;
				lr = b ? ((lr - LNG_HALF) << 1) : (lr << 1);
			end
			sym = {sym[3:0], b};
		end
		nxt       = tok_i;
		nxt.vld   = 1'b1;
		nxt.pos   = tok_i.cv ? pos : '0;
		nxt.last  = !tok_i.cv || (pos == tok_i.cnt - 4'd1);
		nxt.ch    = tok_i.cv ? geo_char(sym) : 8'd0;
		nxt.lng_r = lr;
		nxt.lat_r = ar;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (clear) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		tok_o     = pay_q;
		tok_o.vld = vld_q;
	end

endmodule
